@@ sv/per_context_rx_ring_producer_macros.svh @@
// assertion macros for the rx ring producer
`ifndef PER_CONTEXT_RX_RING_PRODUCER_MACROS_SVH
`define PER_CONTEXT_RX_RING_PRODUCER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PCRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcrp same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define PCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcrp next-cycle check failed");

`endif

@@ sv/pcrp_pkg.sv @@
// types and constants of the per-context rx ring producer
package pcrp_pkg;

    localparam int NUM_CONTEXTS = 32;
    localparam int CTX_BITS     = 5;
    localparam int CTX_IDX_BITS = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int INDEX_BITS   = 16;
    localparam int LEN_BITS     = INDEX_BITS + 1;
    localparam int SLOT_SHIFT   = 5;
    localparam int ADDR_BITS    = 32;
    localparam int COUNT_BITS   = 32;
    localparam int DESC_BITS    = 16;
    localparam int HLEN_BITS    = 17;
    localparam int HIDX_BITS    = 16;
    localparam int SHIFT_BITS   = 3;
    localparam int IN_TDATA_W   = 104;
    localparam int OUT_TDATA_W  = 88;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 3'd2;

    // command codes
    localparam logic CMD_POST = 1'b0;
    localparam logic CMD_SYNC = 1'b1;

    // register index (paddr[2])
    localparam logic REG_REFRESH_SHIFT = 1'b0;

    typedef struct packed {
        logic                 cmd;
        logic [CTX_BITS-1:0]  ctx_id;
        logic [DESC_BITS-1:0] desc_id;
        logic [HLEN_BITS-1:0] host_len;
        logic [HIDX_BITS-1:0] host_prod;
        logic [HIDX_BITS-1:0] host_cons;
        logic [ADDR_BITS-1:0] host_base;
    } t_in_item;

    typedef struct packed {
        logic [DESC_BITS-1:0]  desc_out;
        logic [ADDR_BITS-1:0]  buf_addr;
        logic                  refreshed;
        logic                  not_ready;
        logic [COUNT_BITS-1:0] active_count;
    } t_out_item;

    typedef struct packed {
        logic [LEN_BITS-1:0]   ring_len;
        logic [INDEX_BITS-1:0] prod_index;
        logic [INDEX_BITS-1:0] cons_index;
        logic [ADDR_BITS-1:0]  ring_base;
        logic [COUNT_BITS-1:0] activity;
    } t_entry;

endpackage

@@ sv/per_context_rx_ring_producer.sv @@
// the result is registered: input reg, then result reg
// throughput: one item per cycle while the output is not stalled; each item is one read-modify-write of the ring table
// an item may hit the same context as the one before it, the table is in flip-flops
// reset: synchronous active low, clears the whole table and the valid flags of both stages
// refresh_shift resets to 2
module per_context_rx_ring_producer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ctx_id, desc_id, host_len, host_prod, host_cons, host_base, zero pad
    input  logic [pcrp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // desc_out, buf_addr, refreshed, not_ready, active_count, zero pad
    output logic [pcrp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcrp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pcrp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pcrp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import pcrp_pkg::*;

    logic                    r_in_valid;
    t_in_item                r_in;
    logic                    r_out_valid;
    t_out_item               r_out;
    logic [SHIFT_BITS-1:0]   r_shift;
    t_entry                  r_tab [NUM_CONTEXTS];

    t_in_item                w_in_item;
    logic                    w_adv;
    logic                    w_hit;
    logic [CTX_IDX_BITS-1:0] w_idx;
    t_entry                  w_cur;
    t_entry                  n_entry;
    logic                    w_we;
    t_out_item               n_out;
    logic [ADDR_BITS-1:0]    w_len32;
    logic [ADDR_BITS-1:0]    w_p32;
    logic [ADDR_BITS-1:0]    w_q32;
    logic [ADDR_BITS-1:0]    w_avail;
    logic [ADDR_BITS-1:0]    w_thresh;

    assign w_in_item.cmd       = s_axis_tuser;
    assign w_in_item.ctx_id    = s_axis_tdata[4:0];
    assign w_in_item.desc_id   = s_axis_tdata[20:5];
    assign w_in_item.host_len  = s_axis_tdata[37:21];
    assign w_in_item.host_prod = s_axis_tdata[53:38];
    assign w_in_item.host_cons = s_axis_tdata[69:54];
    assign w_in_item.host_base = s_axis_tdata[101:70];

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.active_count, r_out.not_ready, r_out.refreshed,
                            r_out.buf_addr, r_out.desc_out};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REFRESH_SHIFT) ? APB_DATA_W'(r_shift) : '0;

    assign w_hit = 32'(r_in.ctx_id) < NUM_CONTEXTS;
    assign w_idx = CTX_IDX_BITS'(r_in.ctx_id);
    assign w_cur = r_tab[w_idx];

    // free space modulo 2^32, an index past the length gives a huge value
    assign w_len32  = ADDR_BITS'(w_cur.ring_len);
    assign w_p32    = ADDR_BITS'(w_cur.prod_index);
    assign w_q32    = ADDR_BITS'(w_cur.cons_index);
    assign w_avail  = (w_p32 >= w_q32) ? (w_len32 - w_p32 + w_q32 - 32'd1)
                                       : (w_q32 - w_p32 - 32'd1);
    assign w_thresh = w_len32 >> r_shift;

    always_comb begin
        n_entry = w_cur;
        w_we    = 1'b0;
        n_out   = '0;
        if (r_in.cmd == CMD_POST) begin
            n_out.desc_out  = r_in.desc_id;
            n_out.not_ready = 1'b1;
            if (w_hit) begin
                n_out.active_count = w_cur.activity;
                if (w_cur.ring_len != '0) begin
                    n_entry.prod_index = INDEX_BITS'((LEN_BITS'(w_cur.prod_index)
                                         + LEN_BITS'(1)) & (w_cur.ring_len - LEN_BITS'(1)));
                    n_entry.activity   = w_cur.activity + COUNT_BITS'(1);
                    w_we               = 1'b1;
                    n_out.buf_addr     = w_cur.ring_base
                                         + (ADDR_BITS'(w_cur.prod_index) << SLOT_SHIFT);
                    n_out.not_ready    = 1'b0;
                    n_out.active_count = n_entry.activity;
                end
            end
        end else begin
            if (w_hit) begin
                if (w_cur.ring_len == '0) begin
                    // empty entry takes the whole host record
                    n_entry.ring_len   = LEN_BITS'(r_in.host_len);
                    n_entry.prod_index = INDEX_BITS'(r_in.host_prod);
                    n_entry.cons_index = INDEX_BITS'(r_in.host_cons);
                    n_entry.ring_base  = r_in.host_base;
                    w_we               = 1'b1;
                    n_out.refreshed    = 1'b1;
                end else if (w_avail <= w_thresh) begin
                    n_entry.cons_index = INDEX_BITS'(r_in.host_cons);
                    w_we               = 1'b1;
                    n_out.refreshed    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_shift     <= SHIFT_RESET;
            for (int i = 0; i < NUM_CONTEXTS; i++) begin
                r_tab[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv && w_we) begin
                r_tab[w_idx] <= n_entry;
            end
            if (psel && penable && pwrite && pready && (paddr[2] == REG_REFRESH_SHIFT)) begin
                r_shift <= pwdata[SHIFT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= w_in_item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

`include "per_context_rx_ring_producer_macros.svh"

    `PCRP_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    `PCRP_ASSERT_NEXT(a_in_held_on_stall, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid)
    `PCRP_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, r_out_valid,
        !(r_out.refreshed && r_out.not_ready))
    `PCRP_ASSERT_NOW(a_not_ready_no_addr, i_clk, i_rst_n, r_out_valid && r_out.not_ready,
        r_out.buf_addr == '0)

endmodule
